// File: rtl/cdl_pkg.sv
`timescale 1ns / 1ps
// cdl_pkg: widths, stage positions and types shared by the cone direction limiter.
// No dependencies.
package cdl_pkg;

  localparam int COMP_W    = 24;  // vector component, Q11.12
  localparam int FRAC_W    = 12;
  localparam int COS_W     = 16;  // cone cosine, Q1.14
  localparam int COS_FRAC  = 14;
  localparam int DIR_FRAC  = 28;  // unit direction fraction bits
  localparam int NIN_W     = 44;  // widest vector fed to the normalizer
  localparam int DIR_W     = DIR_FRAC + 2;
  localparam int SHV_W     = DIR_FRAC + 1;  // component after range shift
  localparam int QUO_W     = DIR_FRAC + 1;
  localparam int POS_W     = 6;
  localparam int RAD_W     = 60;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 1;
  localparam int MAG_W     = COMP_W + 1;

  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int NORM_LAT    = 5 + SQRT_STAGES + DIV_STAGES + 1;

  // stage at which each value is held, counted from the accept edge
  localparam int ST_SC   = 2 + SQRT_STAGES;
  localparam int ST_MAG  = ST_SC + 1;
  localparam int ST_DIR  = NORM_LAT;
  localparam int ST_TMP  = ST_DIR + 7;
  localparam int ST_T    = ST_TMP + NORM_LAT;
  localparam int ST_SUM  = ST_T + 3;
  localparam int ST_U    = ST_SUM + NORM_LAT;
  localparam int ST_OUT  = ST_U + 3;

  typedef logic signed [NIN_W-1:0]  nin_t;
  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  lim;
  } res_t;

endpackage

// File: rtl/cdl_if.sv
`timescale 1ns / 1ps
// Item channels of the cone direction limiter: input vectors and limited results.
// Depends on cdl_pkg.
interface cdl_in_if;
  logic valid;
  logic ready;
  logic signed [cdl_pkg::COMP_W-1:0] vec_x;
  logic signed [cdl_pkg::COMP_W-1:0] vec_y;
  logic signed [cdl_pkg::COMP_W-1:0] vec_z;
  logic signed [cdl_pkg::COMP_W-1:0] axis_x;
  logic signed [cdl_pkg::COMP_W-1:0] axis_y;
  logic signed [cdl_pkg::COMP_W-1:0] axis_z;
  logic signed [cdl_pkg::COS_W-1:0]  cone_cosine;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, cone_cosine,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, cone_cosine,
                output ready);
endinterface

interface cdl_out_if;
  logic valid;
  logic ready;
  logic signed [cdl_pkg::COMP_W-1:0] out_x;
  logic signed [cdl_pkg::COMP_W-1:0] out_y;
  logic signed [cdl_pkg::COMP_W-1:0] out_z;
  logic was_limited;

  modport source (output valid, out_x, out_y, out_z, was_limited, input ready);
  modport sink (input valid, out_x, out_y, out_z, was_limited, output ready);
endinterface

// File: rtl/cdl_sqrt.sv
`timescale 1ns / 1ps
// cdl_sqrt: pipelined integer square root, one result bit per stage.
// Gives floor root and remainder (radicand - root^2). Depends on cdl_pkg.
module cdl_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cdl_pkg::RAD_W-1:0]   rad_i,
  output logic [cdl_pkg::ROOT_W-1:0]  root_o,
  output logic [cdl_pkg::REM_W-1:0]   rem_o
);
  localparam int N = cdl_pkg::SQRT_STAGES;
  localparam int W = cdl_pkg::RAD_W;

  logic [W-1:0] n_q [N];
  logic [W-1:0] r_q [N];
  logic [W-1:0] n_d [N];
  logic [W-1:0] r_d [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] n_in;
    logic [W-1:0] r_in;
    logic [W-1:0] trial;
    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end
    // trial bit weight is 4^(N-1-k)
    assign trial = r_in + (W'(1) << (2 * (N - 1 - k)));
    always_comb begin
      if (n_in >= trial) begin
        n_d[k] = n_in - trial;
        r_d[k] = (r_in >> 1) + (W'(1) << (2 * (N - 1 - k)));
      end else begin
        n_d[k] = n_in;
        r_d[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        n_q[k] <= n_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[N-1][cdl_pkg::ROOT_W-1:0];
  assign rem_o  = n_q[N-1][cdl_pkg::REM_W-1:0];
endmodule

// File: rtl/cdl_norm.sv
`timescale 1ns / 1ps
// cdl_norm: pipelined 3D normalizer to a unit direction with 28 fraction bits.
// Range shift, sum of squares, cdl_sqrt for the length, three restoring dividers.
// Depends on cdl_pkg, cdl_sqrt.
module cdl_norm (
  input  logic          clk_i,
  input  logic          en_i,
  input  cdl_pkg::nin_t vec_i [3],
  output cdl_pkg::dir_t dir_o [3]
);
  localparam int NW = cdl_pkg::NIN_W;
  localparam int SW = cdl_pkg::SHV_W;
  localparam int PW = cdl_pkg::POS_W;
  localparam int LW = cdl_pkg::ROOT_W;
  localparam int QW = cdl_pkg::QUO_W;
  localparam int NS = cdl_pkg::SQRT_STAGES;
  localparam int ND = cdl_pkg::DIV_STAGES;

  function automatic logic [PW-1:0] lead_pos(input logic [NW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int b = 0; b < NW; b++) begin
      if (x[b]) p = PW'(b);
    end
    return p;
  endfunction

  // stage 1: magnitudes and largest one
  logic [NW-1:0] m1_q [3];
  logic          ng1_q [3];
  logic [NW-1:0] mx1_q;
  logic [NW-1:0] m1_d [3];
  logic [NW-1:0] mx01;
  logic [NW-1:0] mx1_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_d[i] = vec_i[i][NW-1] ? NW'(-vec_i[i]) : NW'(vec_i[i]);
    end
    mx01  = (m1_d[1] > m1_d[0]) ? m1_d[1] : m1_d[0];
    mx1_d = (m1_d[2] > mx01) ? m1_d[2] : mx01;
  end

  // stage 2: leading one position
  logic [NW-1:0] m2_q [3];
  logic          ng2_q [3];
  logic [PW-1:0] p2_q;
  logic          z2_q;

  // stage 3: shift so the largest lies in [2^28, 2^29)
  logic [SW-1:0] s3_q [3];
  logic [SW-1:0] s3_d [3];
  logic [NW-1:0] sh3 [3];
  logic          ng3_q [3];
  logic          z3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2_q > PW'(cdl_pkg::DIR_FRAC)) begin
        sh3[i] = m2_q[i] >> (p2_q - PW'(cdl_pkg::DIR_FRAC));
      end else begin
        sh3[i] = m2_q[i] << (PW'(cdl_pkg::DIR_FRAC) - p2_q);
      end
      s3_d[i] = sh3[i][SW-1:0];
    end
  end

  // stage 4: squares, stage 5: sum
  logic [2*SW-1:0]          sq4_q [3];
  logic [SW-1:0]            s4_q [3];
  logic                     ng4_q [3];
  logic                     z4_q;
  logic [cdl_pkg::RAD_W-1:0] sum5_q;
  logic [SW-1:0]            s5_q [3];
  logic                     ng5_q [3];
  logic                     z5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i]  <= m1_d[i];
        ng1_q[i] <= vec_i[i][NW-1];
        m2_q[i]  <= m1_q[i];
        ng2_q[i] <= ng1_q[i];
        s3_q[i]  <= s3_d[i];
        ng3_q[i] <= ng2_q[i];
        sq4_q[i] <= s3_q[i] * s3_q[i];
        s4_q[i]  <= s3_q[i];
        ng4_q[i] <= ng3_q[i];
        s5_q[i]  <= s4_q[i];
        ng5_q[i] <= ng4_q[i];
      end
      mx1_q  <= mx1_d;
      p2_q   <= lead_pos(mx1_q);
      z2_q   <= (mx1_q == '0);
      z3_q   <= z2_q;
      z4_q   <= z3_q;
      sum5_q <= cdl_pkg::RAD_W'(sq4_q[0]) + cdl_pkg::RAD_W'(sq4_q[1])
              + cdl_pkg::RAD_W'(sq4_q[2]);
      z5_q   <= z4_q;
    end
  end

  logic [LW-1:0]           len;
  logic [cdl_pkg::REM_W-1:0] len_rem;

  cdl_sqrt u_len (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (sum5_q),
    .root_o (len),
    .rem_o  (len_rem)
  );

  // side data waits while the length is worked out
  logic [SW-1:0] sdl_q [NS][3];
  logic          ndl_q [NS][3];
  logic          zdl_q [NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdl_q[0] <= s5_q;
      ndl_q[0] <= ng5_q;
      zdl_q[0] <= z5_q;
      for (int k = 1; k < NS; k++) begin
        sdl_q[k] <= sdl_q[k-1];
        ndl_q[k] <= ndl_q[k-1];
        zdl_q[k] <= zdl_q[k-1];
      end
    end
  end

  // restoring division, one quotient bit per stage; s <= len so quotient <= 2^28
  logic [LW-1:0] rm_q  [ND][3];
  logic [QW-1:0] qo_q  [ND][3];
  logic [LW-1:0] ln_q  [ND];
  logic          ngd_q [ND][3];
  logic          zd_q  [ND];
  logic [LW-1:0] rm_d  [ND][3];
  logic [QW-1:0] qo_d  [ND][3];

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [LW:0]   part [3];
    logic          ge   [3];
    logic [LW-1:0] dv;
    if (k == 0) begin : g_first
      assign dv = len;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign part[i] = (LW + 1)'(sdl_q[NS-1][i]);
        assign ge[i]   = part[i] >= {1'b0, dv};
        assign rm_d[k][i] = ge[i] ? LW'(part[i] - {1'b0, dv}) : LW'(part[i]);
        assign qo_d[k][i] = QW'(ge[i]);
      end
    end else begin : g_next
      assign dv = ln_q[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign part[i] = {rm_q[k-1][i], 1'b0};
        assign ge[i]   = part[i] >= {1'b0, dv};
        assign rm_d[k][i] = ge[i] ? LW'(part[i] - {1'b0, dv}) : LW'(part[i]);
        assign qo_d[k][i] = {qo_q[k-1][i][QW-2:0], ge[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ND; k++) begin
        rm_q[k] <= rm_d[k];
        qo_q[k] <= qo_d[k];
      end
      ln_q[0]  <= len;
      ngd_q[0] <= ndl_q[NS-1];
      zd_q[0]  <= zdl_q[NS-1];
      for (int k = 1; k < ND; k++) begin
        ln_q[k]  <= ln_q[k-1];
        ngd_q[k] <= ngd_q[k-1];
        zd_q[k]  <= zd_q[k-1];
      end
    end
  end

  // sign back on; a zero vector stays zero
  cdl_pkg::dir_t dir_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (zd_q[ND-1]) begin
          dir_q[i] <= '0;
        end else if (ngd_q[ND-1][i]) begin
          dir_q[i] <= -$signed({1'b0, qo_q[ND-1][i]});
        end else begin
          dir_q[i] <= $signed({1'b0, qo_q[ND-1][i]});
        end
      end
    end
  end

  assign dir_o = dir_q;
endmodule

// File: rtl/cone_direction_limit_top.sv
`timescale 1ns / 1ps
// cone_direction_limit_top: clamps a 3D vector into a cone around an axis.
// Depends on cdl_pkg, cdl_if, cdl_sqrt, cdl_norm.
//
// Usage:
//   item_i carries a vector and a unit axis (Q11.12) and the cone cosine (Q1.14).
//   res_o returns one result per item, in order: the limited vector, saturated
//   to 24 bits, and was_limited.
//   Throughput: one item per cycle; ready stays high while the output buffer
//   has room, so items stream back to back.
//   The work is a 208-stage pipeline: three normalizers, each a 30-stage
//   square root and 29-stage dividers, dominate the depth, plus a square root
//   for the magnitude and one for the perpendicular weight in parallel.
//   Reset clears the stage valid bits and the count and pointers of the
//   two-entry output buffer; the data registers are not reset.
//   When the receiver stalls, finished results collect in the output buffer;
//   once it is full the whole pipeline holds and ready drops. Nothing is
//   dropped or repeated.
module cone_direction_limit_top (
  input logic            clk_i,
  input logic            rst_ni,
  cdl_in_if.sink         item_i,
  cdl_out_if.source      res_o
);
  localparam int CW   = cdl_pkg::COMP_W;
  localparam int NW   = cdl_pkg::NIN_W;
  localparam int DIR  = cdl_pkg::ST_DIR;
  localparam int TMP  = cdl_pkg::ST_TMP;
  localparam int TS   = cdl_pkg::ST_T;
  localparam int SUM  = cdl_pkg::ST_SUM;
  localparam int US   = cdl_pkg::ST_U;
  localparam int OUTS = cdl_pkg::ST_OUT;
  localparam int MAGS = cdl_pkg::ST_MAG;
  localparam int AEND = DIR + 4;  // last stage that reads the axis and cosine

  logic       en;
  logic [1:0] cnt_q;
  logic       wp_q;
  logic       rp_q;
  logic       push;
  logic       pop;
  cdl_pkg::res_t fifo_q [2];

  assign en           = (cnt_q != 2'd2);
  assign item_i.ready = en;

  cdl_pkg::comp_t vin [3];
  cdl_pkg::comp_t ain [3];
  always_comb begin
    vin[0] = item_i.vec_x;
    vin[1] = item_i.vec_y;
    vin[2] = item_i.vec_z;
    ain[0] = item_i.axis_x;
    ain[1] = item_i.axis_y;
    ain[2] = item_i.axis_z;
  end

  // valid bits
  logic vld_q [1:OUTS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= OUTS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= item_i.valid;
      for (int k = 2; k <= OUTS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // input side lines
  cdl_pkg::comp_t v_q [1:OUTS-1][3];
  cdl_pkg::comp_t a_q [1:AEND][3];
  logic signed [cdl_pkg::COS_W-1:0] c_q [1:AEND];

  // magnitude and perpendicular weight front end
  logic [2*CW-2:0]   vsq_q [3];
  logic [2*CW-1:0]   msum_q;
  logic [2*cdl_pkg::COS_W-2:0] csq_q;
  logic [cdl_pkg::ROOT_W-1:0] diff_q;
  logic signed [2*CW-1:0] vp [3];
  logic signed [2*cdl_pkg::COS_W-1:0] cp;
  logic signed [2*cdl_pkg::COS_W:0] dd;

  always_comb begin
    for (int i = 0; i < 3; i++) vp[i] = vin[i] * vin[i];
    cp = item_i.cone_cosine * item_i.cone_cosine;
    dd = ((2 * cdl_pkg::COS_W + 1)'(1) << (2 * cdl_pkg::COS_FRAC))
       - $signed({2'b00, csq_q});
  end

  logic [cdl_pkg::ROOT_W-1:0] root_m;
  logic [cdl_pkg::REM_W-1:0]  rem_m;
  logic [cdl_pkg::ROOT_W-1:0] root_c;
  logic [cdl_pkg::REM_W-1:0]  rem_c;

  cdl_sqrt u_mag_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (cdl_pkg::RAD_W'(msum_q)),
    .root_o (root_m),
    .rem_o  (rem_m)
  );

  // sqrt(|1 - c*c|) with 28 fraction bits
  cdl_sqrt u_sc_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({2'b00, diff_q, {(2 * (cdl_pkg::DIR_FRAC - cdl_pkg::COS_FRAC)){1'b0}}}),
    .root_o (root_c),
    .rem_o  (rem_c)
  );

  logic [cdl_pkg::MAG_W-1:0]  mag_q [MAGS:US];
  logic [cdl_pkg::SHV_W-1:0]  sc_q  [MAGS:TS];

  // first normalizer: direction of the input vector
  cdl_pkg::nin_t n1_in [3];
  cdl_pkg::dir_t dir1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) n1_in[i] = NW'(vin[i]);
  end

  cdl_norm u_norm_v (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (n1_in),
    .dir_o (dir1)
  );

  // dot product, compare, projection off the axis
  logic signed [53:0] dp_q [3];
  logic signed [53:0] dpm [3];
  logic signed [55:0] dot_q;
  logic signed [55:0] dtw;
  logic signed [55:0] cs;
  logic signed [NW-1:0] dtr_q;
  logic signed [32:0] dtc_q;
  logic signed [56:0] apm [3];
  logic signed [56:0] ap_q [3];
  logic signed [56:0] atw [3];
  logic signed [NW-1:0] apt_q [3];
  logic signed [39:0] acm [3];
  logic signed [41:0] ac_q [DIR+5:SUM-1][3];
  cdl_pkg::dir_t d_q [DIR+1:TMP-1][3];
  cdl_pkg::nin_t tmp_q [3];
  logic lim_q [DIR+3:OUTS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dpm[i] = dir1[i] * a_q[DIR][i];
      apm[i] = a_q[AEND][i] * dtc_q;
      acm[i] = a_q[AEND][i] * c_q[AEND];
      atw[i] = (ap_q[i] + (ap_q[i] < 0 ? 57'sd4095 : 57'sd0)) >>> cdl_pkg::FRAC_W;
    end
    dtw = (dot_q + (dot_q < 0 ? 56'sd4095 : 56'sd0)) >>> cdl_pkg::FRAC_W;
    cs  = 56'(c_q[DIR+2]) <<< (cdl_pkg::DIR_FRAC + cdl_pkg::FRAC_W - cdl_pkg::COS_FRAC);
  end

  // second normalizer: perpendicular direction
  cdl_pkg::dir_t dir2 [3];
  cdl_norm u_norm_p (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (tmp_q),
    .dir_o (dir2)
  );

  logic signed [59:0] tsm [3];
  logic signed [59:0] tsc_q [3];
  logic signed [59:0] tsw [3];
  logic signed [31:0] tsd_q [3];
  cdl_pkg::nin_t sm_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsm[i] = dir2[i] * $signed({1'b0, sc_q[TS]});
      tsw[i] = (tsc_q[i] + (tsc_q[i] < 0 ? 60'sd268435455 : 60'sd0)) >>> cdl_pkg::DIR_FRAC;
    end
  end

  // third normalizer: rebuilt direction
  cdl_pkg::dir_t dir3 [3];
  cdl_norm u_norm_s (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (sm_q),
    .dir_o (dir3)
  );

  logic signed [55:0] umm [3];
  logic signed [55:0] um_q [3];
  logic signed [55:0] umw [3];
  logic signed [26:0] rr_q [3];
  cdl_pkg::comp_t rs [3];
  cdl_pkg::res_t  res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      umm[i] = dir3[i] * $signed({1'b0, mag_q[US]});
      umw[i] = (um_q[i] + (um_q[i] < 0 ? 56'sd268435455 : 56'sd0)) >>> cdl_pkg::DIR_FRAC;
      if (!lim_q[OUTS-1]) begin
        rs[i] = v_q[OUTS-1][i];
      end else if (rr_q[i] > 27'sd8388607) begin
        rs[i] = 24'sh7fffff;
      end else if (rr_q[i] < -27'sd8388608) begin
        rs[i] = 24'sh800000;
      end else begin
        rs[i] = rr_q[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      v_q[1] <= vin;
      a_q[1] <= ain;
      c_q[1] <= item_i.cone_cosine;
      for (int i = 0; i < 3; i++) vsq_q[i] <= vp[i][2*CW-2:0];
      csq_q <= cp[2*cdl_pkg::COS_W-2:0];
      for (int k = 2; k <= OUTS - 1; k++) v_q[k] <= v_q[k-1];
      for (int k = 2; k <= AEND; k++) begin
        a_q[k] <= a_q[k-1];
        c_q[k] <= c_q[k-1];
      end
      // stage 2
      msum_q <= (2*CW)'(vsq_q[0]) + (2*CW)'(vsq_q[1]) + (2*CW)'(vsq_q[2]);
      diff_q <= dd[2*cdl_pkg::COS_W] ? cdl_pkg::ROOT_W'(-dd) : cdl_pkg::ROOT_W'(dd);
      // magnitude rounded to nearest, and perpendicular weight
      mag_q[MAGS] <= cdl_pkg::MAG_W'(root_m)
                   + cdl_pkg::MAG_W'(rem_m > cdl_pkg::REM_W'(root_m));
      for (int k = MAGS + 1; k <= US; k++) mag_q[k] <= mag_q[k-1];
      sc_q[MAGS] <= root_c[cdl_pkg::SHV_W-1:0];
      for (int k = MAGS + 1; k <= TS; k++) sc_q[k] <= sc_q[k-1];
      // dot product and limit decision
      dp_q  <= dpm;
      dot_q <= 56'(dp_q[0]) + 56'(dp_q[1]) + 56'(dp_q[2]);
      dtr_q <= dtw[NW-1:0];
      lim_q[DIR+3] <= cs > dot_q;
      for (int k = DIR + 4; k <= OUTS - 1; k++) lim_q[k] <= lim_q[k-1];
      if (dtr_q > 44'sh0_0080000000) begin
        dtc_q <= 33'sh080000000;
      end else if (dtr_q < -44'sh0_0080000000) begin
        dtc_q <= -33'sh080000000;
      end else begin
        dtc_q <= dtr_q[32:0];
      end
      // projection of the axis and axis * cosine
      ap_q <= apm;
      for (int i = 0; i < 3; i++) begin
        ac_q[DIR+5][i] <= 42'(acm[i]) <<< (cdl_pkg::DIR_FRAC - cdl_pkg::FRAC_W
                                           - cdl_pkg::COS_FRAC);
        apt_q[i] <= atw[i][NW-1:0];
        tmp_q[i] <= NW'(d_q[TMP-1][i]) - apt_q[i];
      end
      for (int k = DIR + 6; k <= SUM - 1; k++) ac_q[k] <= ac_q[k-1];
      d_q[DIR+1] <= dir1;
      for (int k = DIR + 2; k <= TMP - 1; k++) d_q[k] <= d_q[k-1];
      // weighted perpendicular plus axis term
      tsc_q <= tsm;
      for (int i = 0; i < 3; i++) begin
        tsd_q[i] <= tsw[i][31:0];
        sm_q[i]  <= NW'(tsd_q[i]) + NW'(ac_q[SUM-1][i]);
      end
      // scale back to the input magnitude, saturate
      um_q <= umm;
      for (int i = 0; i < 3; i++) rr_q[i] <= umw[i][26:0];
      res_q.x   <= rs[0];
      res_q.y   <= rs[1];
      res_q.z   <= rs[2];
      res_q.lim <= lim_q[OUTS-1];
    end
  end

  // two-entry output buffer
  assign push = en && vld_q[OUTS];
  assign pop  = (cnt_q != 2'd0) && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= res_q;
  end

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.out_x       = fifo_q[rp_q].x;
  assign res_o.out_y       = fifo_q[rp_q].y;
  assign res_o.out_z       = fifo_q[rp_q].z;
  assign res_o.was_limited = fifo_q[rp_q].lim;
endmodule
